@@ rtl/gwmn_pkg.sv @@
// ----------------------------------------------------------------------------
// gwmn_pkg
// Shared widths, codes, handshake command/status structs and neighbor offsets
// for the grid wall map neighbor block.
// ----------------------------------------------------------------------------
package gwmn_pkg;

    localparam int COORD_W   = 6;   // cell coordinate width
    localparam int RAD_W     = 8;   // radius, unsigned Q4.4
    localparam int CFG_W     = 7;   // configuration register width
    localparam int CFG_IDX_W = 2;   // configuration register index width
    localparam int NUM_NB    = 8;   // neighbors around one cell

    localparam logic KIND_PAINT = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic accept;
        logic pinit;
        logic prd;
        logic pwr;
        logic qrd;
        logic qcap;
        logic load_ack;
        logic load_nb;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic clr_done;
        logic col_done;
        logic qc_done;
        logic slot_free;
        logic nb_final;
    } t_stat;

    // Neighbor k: column offset outer (-1,0,1), row offset inner, center skipped.
    function automatic logic [COORD_W-1:0] nb_off_x(input logic [2:0] k);
        logic [COORD_W-1:0] off;
        case (k)
            3'd0, 3'd1, 3'd2: off = {COORD_W{1'b1}};
            3'd3, 3'd4:       off = '0;
            default:          off = COORD_W'(1);
        endcase
        return off;
    endfunction

    function automatic logic [COORD_W-1:0] nb_off_y(input logic [2:0] k);
        logic [COORD_W-1:0] off;
        case (k)
            3'd0, 3'd3, 3'd5: off = {COORD_W{1'b1}};
            3'd1, 3'd6:       off = '0;
            default:          off = COORD_W'(1);
        endcase
        return off;
    endfunction

endpackage

@@ rtl/gwmn_item_if.sv @@
// ----------------------------------------------------------------------------
// gwmn_item_if
// Input item channel: paint or query request.
// ----------------------------------------------------------------------------
interface gwmn_item_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [gwmn_pkg::COORD_W-1:0]  cell_x;
    logic [gwmn_pkg::COORD_W-1:0]  cell_y;
    logic [gwmn_pkg::RAD_W-1:0]    radius;

    modport source (output valid, kind, cell_x, cell_y, radius, input ready);
    modport sink   (input valid, kind, cell_x, cell_y, radius, output ready);
endinterface

@@ rtl/gwmn_result_if.sv @@
// ----------------------------------------------------------------------------
// gwmn_result_if
// Result item channel: free neighbor, not-found marker or paint acknowledge.
// ----------------------------------------------------------------------------
interface gwmn_result_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [gwmn_pkg::COORD_W-1:0]  near_x;
    logic [gwmn_pkg::COORD_W-1:0]  near_y;
    logic                          paint_done;
    logic                          last;

    modport source (output valid, found, near_x, near_y, paint_done, last, input ready);
    modport sink   (input valid, found, near_x, near_y, paint_done, last, output ready);
endinterface

@@ rtl/gwmn_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gwmn_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gwmn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gwmn_pkg::CFG_IDX_W-1:0]  index;
    logic [gwmn_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/gwmn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gwmn_ctrl
// Sequencer: clear pass, paint column walk, query column reads, result issue.
// ----------------------------------------------------------------------------
module gwmn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gwmn_pkg::t_stat  i_stat,
    output gwmn_pkg::t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_PINIT = 9'b000000100,
        S_PRD   = 9'b000001000,
        S_PWR   = 9'b000010000,
        S_PACK  = 9'b000100000,
        S_QRD   = 9'b001000000,
        S_QCAP  = 9'b010000000,
        S_QOUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_stat.in_kind == gwmn_pkg::KIND_PAINT) ? S_PINIT : S_QRD;
                end
            end
            S_PINIT: begin
                o_cmd.pinit = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state = S_PWR;
            end
            S_PWR: begin
                o_cmd.pwr = 1'b1;
                n_state = i_stat.col_done ? S_PACK : S_PRD;
            end
            S_PACK: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_ack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_QRD: begin
                o_cmd.qrd = 1'b1;
                n_state = S_QCAP;
            end
            S_QCAP: begin
                o_cmd.qcap = 1'b1;
                n_state = i_stat.qc_done ? S_QOUT : S_QRD;
            end
            S_QOUT: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_nb = 1'b1;
                    if (i_stat.nb_final) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/gwmn_dpath.sv @@
// ----------------------------------------------------------------------------
// gwmn_dpath
// Wall store (one word per column), disc mask, neighbor pick, output register.
// ----------------------------------------------------------------------------
module gwmn_dpath #(
    parameter int W_USE = 64,
    parameter int H_USE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gwmn_pkg::t_cmd                  i_cmd,
    output gwmn_pkg::t_stat                 o_stat,
    // item payload
    input  logic                            i_in_valid,
    input  logic                            i_kind,
    input  logic [gwmn_pkg::COORD_W-1:0]    i_cell_x,
    input  logic [gwmn_pkg::COORD_W-1:0]    i_cell_y,
    input  logic [gwmn_pkg::RAD_W-1:0]      i_radius,
    // configuration write
    input  logic                            i_cfg_we,
    input  logic [gwmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gwmn_pkg::CFG_W-1:0]      i_cfg_data,
    // result register
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_found,
    output logic [gwmn_pkg::COORD_W-1:0]    o_near_x,
    output logic [gwmn_pkg::COORD_W-1:0]    o_near_y,
    output logic                            o_paint_done,
    output logic                            o_last
);

    localparam int XA_W = $clog2(W_USE);
    localparam int CW   = gwmn_pkg::COORD_W;
    localparam int NB   = gwmn_pkg::NUM_NB;

    // ---------------- config
    logic [gwmn_pkg::CFG_W-1:0] r_gw, r_gh, uw, uh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= gwmn_pkg::GRID_RESET;
            r_gh <= gwmn_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gwmn_pkg::REG_GRID_WIDTH:  r_gw <= i_cfg_data;
                gwmn_pkg::REG_GRID_HEIGHT: r_gh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign uw = (r_gw > 7'(W_USE)) ? 7'(W_USE) : r_gw;
    assign uh = (r_gh > 7'(H_USE)) ? 7'(H_USE) : r_gh;

    // ---------------- item registers
    logic [CW-1:0]                r_cx, r_cy;
    logic [gwmn_pkg::RAD_W-1:0]   r_rad;
    logic signed [5:0]            r_dx;
    logic [1:0]                   r_qc;
    logic [7:0]                   r_l;
    logic                         r_rnz;
    logic [15:0]                  r2;

    assign r2 = 16'({8'd0, r_rad} * {8'd0, r_rad});

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cx  <= i_cell_x;
            r_cy  <= i_cell_y;
            r_rad <= i_radius;
            r_dx  <= -6'sd16;
            r_qc  <= '0;
        end
        if (i_cmd.pinit) begin
            // 256*d2 < r*r  <=>  d2 <= (r*r-1)>>8 for r > 0
            r_l   <= 8'((r2 - 16'd1) >> 8);
            r_rnz <= (r_rad != '0);
        end
        if (i_cmd.pwr)  r_dx <= r_dx + 6'sd1;
        if (i_cmd.qcap) r_qc <= r_qc + 2'd1;
    end

    // ---------------- disc column mask
    logic signed [7:0] px;
    logic              x_in;
    logic [5:0]        adx6;
    logic [4:0]        adx;
    logic [8:0]        sq;
    logic signed [9:0] rem;
    logic [16:0]       hit;
    logic [4:0]        cnt, kspan;
    logic signed [8:0] lo, hi;
    logic [H_USE-1:0]  mask;

    assign px   = $signed({2'b00, r_cx}) + $signed({{2{r_dx[5]}}, r_dx});
    assign x_in = !px[7] && (px[6:0] < uw);
    assign adx6 = r_dx[5] ? 6'(-r_dx) : 6'(r_dx);
    assign adx  = adx6[4:0];
    assign sq   = 9'({4'd0, adx} * {4'd0, adx});
    assign rem  = $signed({2'b00, r_l}) - $signed({1'b0, sq});

    always_comb begin
        for (int j = 0; j < 17; j++) begin
            hit[j] = r_rnz && (rem >= $signed(10'(j * j)));
        end
    end

    assign cnt   = 5'($countones(hit));
    assign kspan = cnt - 5'd1;
    assign lo    = $signed({3'b000, r_cy}) - $signed({4'b0000, kspan});
    assign hi    = $signed({3'b000, r_cy}) + $signed({4'b0000, kspan});

    always_comb begin
        for (int y = 0; y < H_USE; y++) begin
            mask[y] = (cnt != '0) && ($signed(9'(y)) >= lo) && ($signed(9'(y)) <= hi)
                      && (7'(y) < uh);
        end
    end

    // ---------------- query column address and bounds
    logic signed [7:0] qx;
    logic              q_in, center_ok;
    logic [2:0]        ybits_ok, nb, free;
    logic [H_USE+1:0]  ext;

    assign qx        = $signed({2'b00, r_cx}) + $signed({6'd0, r_qc}) - 8'sd1;
    assign q_in      = !qx[7] && (qx[6:0] < uw);
    assign center_ok = ({1'b0, r_cx} < uw) && ({1'b0, r_cy} < uh);
    assign ybits_ok  = {({1'b0, r_cy} + 7'd1) < uh, {1'b0, r_cy} < uh, r_cy != '0};

    // ---------------- wall store
    logic [H_USE-1:0] mem [W_USE];
    logic [H_USE-1:0] r_rdata, r_mask, wdata;
    logic [XA_W-1:0]  r_clr, r_wa, raddr, waddr;
    logic             r_wok, we;

    always_comb begin
        raddr = '0;
        if (i_cmd.prd && x_in) raddr = px[XA_W-1:0];
        if (i_cmd.qrd && q_in) raddr = qx[XA_W-1:0];
    end

    assign we    = i_cmd.clr_step || (i_cmd.pwr && r_wok);
    assign waddr = i_cmd.clr_step ? r_clr : r_wa;
    assign wdata = i_cmd.clr_step ? '0 : (r_rdata | r_mask);

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + XA_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prd) begin
            r_mask <= mask;
            r_wa   <= px[XA_W-1:0];
            r_wok  <= x_in;
        end
    end

    // rows y-1, y, y+1 of the column just read (pads cover the edges)
    assign ext  = {1'b0, r_rdata, 1'b0};
    assign nb   = 3'(ext >> r_cy);
    assign free = ~nb & ybits_ok & {3{q_in && center_ok}};

    // ---------------- pending free neighbors
    logic [NB-1:0] r_pend, low;
    logic [2:0]    kidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend <= '0;
        end else if (i_cmd.qcap) begin
            case (r_qc)
                2'd0:    r_pend[2:0] <= free;
                2'd1:    r_pend[4:3] <= {free[2], free[0]};
                2'd2:    r_pend[7:5] <= free;
                default: ;
            endcase
        end else if (i_cmd.load_nb) begin
            r_pend <= r_pend & ~low;
        end
    end

    assign low = r_pend & (~r_pend + NB'(1));

    always_comb begin
        kidx = '0;
        for (int j = 0; j < NB; j++) begin
            if (low[j]) kidx = 3'(j);
        end
    end

    // ---------------- result register
    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_ack || i_cmd.load_nb) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack) begin
            o_found      <= 1'b0;
            o_near_x     <= '0;
            o_near_y     <= '0;
            o_paint_done <= 1'b1;
            o_last       <= 1'b1;
        end else if (i_cmd.load_nb) begin
            o_found      <= (r_pend != '0);
            o_near_x     <= (r_pend != '0) ? r_cx + gwmn_pkg::nb_off_x(kidx) : '0;
            o_near_y     <= (r_pend != '0) ? r_cy + gwmn_pkg::nb_off_y(kidx) : '0;
            o_paint_done <= 1'b0;
            o_last       <= ((r_pend & ~low) == '0);
        end
    end

    assign o_out_valid = r_ov;

    // ---------------- status
    assign o_stat.in_valid  = i_in_valid;
    assign o_stat.in_kind   = i_kind;
    assign o_stat.clr_done  = (r_clr == XA_W'(W_USE - 1));
    assign o_stat.col_done  = (r_dx == 6'sd16);
    assign o_stat.qc_done   = (r_qc == 2'd2);
    assign o_stat.slot_free = !r_ov || i_out_ready;
    assign o_stat.nb_final  = ((r_pend & ~low) == '0);

endmodule

@@ rtl/grid_wall_map_neighbours.sv @@
// ----------------------------------------------------------------------------
// grid_wall_map_neighbours
// Wall bit map of a grid with disc painting and eight-connected free-cell query.
// ----------------------------------------------------------------------------
// Usage:
//   i_item   : one item per request. kind = paint marks every in-bounds cell
//              with 256*(dx*dx+dy*dy) < radius*radius as wall; kind = query
//              lists the free in-bounds cells around (cell_x, cell_y).
//   o_result : paint gives one item with paint_done = last = 1. A query gives
//              its free neighbors (column offset outer, row offset inner,
//              last on the final one), or one item with found = 0 if none.
//   i_cfg    : index 0 grid_width, 1 grid_height; always ready, write only
//              while no item is in flight. Other indexes are ignored.
// Sequence (one item at a time, ready only between items):
//   paint : accept, initialise, then walk the disc box one column per
//           read-modify-write pair, then the acknowledge.
//   query : accept, then three column reads of the wall store, then
//           one result per cycle while the result register is free.
// Reset: the store is cleared by a pass over min(GRID_W,64) columns, one column
//   a cycle; items are held off during it, configuration writes are taken.
// Stall: the result register holds until taken; the next item is accepted
//   while the final result of the previous one still waits.
// ----------------------------------------------------------------------------
module grid_wall_map_neighbours #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gwmn_item_if.sink     i_item,
    gwmn_result_if.source o_result,
    gwmn_cfg_if.sink      i_cfg
);

    // Only the first 64 columns and rows can ever be addressed.
    localparam int W_USE = (GRID_W < 64) ? GRID_W : 64;
    localparam int H_USE = (GRID_H < 64) ? GRID_H : 64;

    gwmn_pkg::t_cmd  cmd;
    gwmn_pkg::t_stat stat;

    assign i_item.ready = cmd.in_ready;
    assign i_cfg.ready  = 1'b1;

    gwmn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gwmn_dpath #(
        .W_USE (W_USE),
        .H_USE (H_USE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_valid   (i_item.valid),
        .i_kind       (i_item.kind),
        .i_cell_x     (i_item.cell_x),
        .i_cell_y     (i_item.cell_y),
        .i_radius     (i_item.radius),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_found      (o_result.found),
        .o_near_x     (o_result.near_x),
        .o_near_y     (o_result.near_y),
        .o_paint_done (o_result.paint_done),
        .o_last       (o_result.last)
    );

endmodule

@@ rtl/gwmn_checker.sv @@
// ----------------------------------------------------------------------------
// gwmn_checker
// Port-level checks on the item and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module gwmn_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_found,
    input logic i_paint_done,
    input logic i_last
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: ready falls after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while busy");

    // paint acknowledge is a single final item with no cell
    a_paint_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_paint_done |-> i_last && !i_found)
        else $error("malformed paint acknowledge");

    // a not-found result always closes its item
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_last)
        else $error("not-found result without last");

endmodule

bind grid_wall_map_neighbours gwmn_checker u_gwmn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_found      (o_result.found),
    .i_paint_done (o_result.paint_done),
    .i_last       (o_result.last)
);

@@ test/grid_wall_map_neighbours_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_wall_map_neighbours_tb
// Self-checking bench for the wall map: paints discs and queries the free
// cells around a center, then checks every result item against a local
// copy of the map and of the grid size registers.
// ----------------------------------------------------------------------------
module grid_wall_map_neighbours_tb;

    localparam int GRID_SIDE   = 64;       // matches the default GRID_W/GRID_H
    localparam int CYCLE_LIMIT = 300000;   // several times the slowest clean run
    localparam int SETTLE      = 8;        // quiet cycles after the last result
    localparam int PHASE_ITEMS = 56;
    localparam int PAUSE_AT    = 20;       // item after which the sender waits

    // Register indexes the block must ignore.
    localparam logic [gwmn_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [gwmn_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic                         kind;
        logic [gwmn_pkg::COORD_W-1:0] cell_x;
        logic [gwmn_pkg::COORD_W-1:0] cell_y;
        logic [gwmn_pkg::RAD_W-1:0]   radius;
    } t_grid_cmd;

    typedef struct packed {
        logic                         found;
        logic [gwmn_pkg::COORD_W-1:0] near_x;
        logic [gwmn_pkg::COORD_W-1:0] near_y;
        logic                         paint_done;
        logic                         last;
    } t_cell_result;

    // ------------------------------------------------------------------------
    // Scoreboard: own wall map and grid size, queue of expected result items.
    // ------------------------------------------------------------------------
    class free_cell_board;
        bit                         wall [GRID_SIDE][GRID_SIDE];   // [column][row]
        logic [gwmn_pkg::CFG_W-1:0] width_reg;
        logic [gwmn_pkg::CFG_W-1:0] height_reg;
        t_cell_result               pending_cells[$];
        int                         mismatches;

        function new();
            width_reg  = gwmn_pkg::GRID_RESET;
            height_reg = gwmn_pkg::GRID_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [gwmn_pkg::CFG_IDX_W-1:0] idx,
                              logic [gwmn_pkg::CFG_W-1:0] val);
            if (idx == gwmn_pkg::REG_GRID_WIDTH)
                width_reg = val;
            else if (idx == gwmn_pkg::REG_GRID_HEIGHT)
                height_reg = val;
        endfunction

        function int span(logic [gwmn_pkg::CFG_W-1:0] val);
            return (val > GRID_SIDE) ? GRID_SIDE : int'(val);
        endfunction

        function bit on_grid(int x, int y);
            return x >= 0 && y >= 0 && x < span(width_reg) && y < span(height_reg);
        endfunction

        // append one expected result item
        function void queue_expected(t_cell_result res);
            pending_cells = {pending_cells, res};
        endfunction

        function void note_item(t_grid_cmd cmd);
            int cx;
            int cy;
            int rr;
            int n;
            int fx[8];
            int fy[8];
            cx = cmd.cell_x;
            cy = cmd.cell_y;
            rr = cmd.radius;
            n  = 0;
            if (cmd.kind == gwmn_pkg::KIND_PAINT) begin
                // Q4.4 radius: compare squared distance scaled by 256
                for (int dx = -16; dx <= 16; dx++)
                    for (int dy = -16; dy <= 16; dy++)
                        if ((dx * dx + dy * dy) * 256 < rr * rr && on_grid(cx + dx, cy + dy))
                            wall[cx + dx][cy + dy] = 1'b1;
                queue_expected(t_cell_result'{found: 1'b0, near_x: '0, near_y: '0,
                                              paint_done: 1'b1, last: 1'b1});
                return;
            end
            if (on_grid(cx, cy)) begin
                for (int dx = -1; dx <= 1; dx++)
                    for (int dy = -1; dy <= 1; dy++)
                        if (!(dx == 0 && dy == 0) && on_grid(cx + dx, cy + dy)
                                && !wall[cx + dx][cy + dy]) begin
                            fx[n] = cx + dx;
                            fy[n] = cy + dy;
                            n++;
                        end
            end
            if (n == 0)
                queue_expected(t_cell_result'{found: 1'b0, near_x: '0, near_y: '0,
                                              paint_done: 1'b0, last: 1'b1});
            for (int i = 0; i < n; i++)
                queue_expected(t_cell_result'{found: 1'b1,
                                              near_x: gwmn_pkg::COORD_W'(fx[i]),
                                              near_y: gwmn_pkg::COORD_W'(fy[i]),
                                              paint_done: 1'b0,
                                              last: (i == n - 1)});
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_cell_result got);
            t_cell_result want;
            if (pending_cells.size() == 0) begin
                $display("%0t: expected no result, actual found %0d x %0d y %0d paint_done %0d last %0d",
                         $time, got.found, got.near_x, got.near_y, got.paint_done,
                         got.last);
                mismatches++;
                return;
            end
            want = pending_cells.pop_front();
            match_field("found", want.found, got.found);
            match_field("near_x", want.near_x, got.near_x);
            match_field("near_y", want.near_y, got.near_y);
            match_field("paint_done", want.paint_done, got.paint_done);
            match_field("last", want.last, got.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gwmn_item_if   item_ch();
    gwmn_result_if result_ch();
    gwmn_cfg_if    cfg_ch();

    free_cell_board board = new();

    int send_idle_pct = 13;
    int recv_idle_pct = 76;
    int cycles        = 0;

    // Grid size per random phase: reset size, extremes, zero and oversize values.
    int phase_w[6] = '{64, 1, 127, 0, 13, 64};
    int phase_h[6] = '{64, 1, 100, 37, 2, 1};

    grid_wall_map_neighbours dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run guard: a hung handshake ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check the item taken at this edge, then pick next ready.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready)
                board.check_result(t_cell_result'{found: result_ch.found,
                                                  near_x: result_ch.near_x,
                                                  near_y: result_ch.near_y,
                                                  paint_done: result_ch.paint_done,
                                                  last: result_ch.last});
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One item on the input channel. Valid stays high into the next item unless
    // a gap is rolled or the caller stops after this one.
    task automatic feed_item(input logic kind,
                             input logic [gwmn_pkg::COORD_W-1:0] x,
                             input logic [gwmn_pkg::COORD_W-1:0] y,
                             input logic [gwmn_pkg::RAD_W-1:0] r,
                             input bit stop_after);
        t_grid_cmd cmd;
        bit        hold;
        cmd = '{kind: kind, cell_x: x, cell_y: y, radius: r};
        item_ch.valid  <= 1'b1;
        item_ch.kind   <= kind;
        item_ch.cell_x <= x;
        item_ch.cell_y <= y;
        item_ch.radius <= r;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
        board.note_item(cmd);
        hold = !stop_after && ($urandom_range(99) >= send_idle_pct);
        if (!hold) begin
            item_ch.valid <= 1'b0;
            if (!stop_after) begin
                @(posedge i_clk);
                while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
            end
        end
    endtask

    // Wait until every expected result is in, then let the block go quiet.
    task automatic drain_results();
        while (board.pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Width, an ignored index, then height, back to back on the config channel.
    task automatic write_grid_size(input logic [gwmn_pkg::CFG_W-1:0] w,
                                   input logic [gwmn_pkg::CFG_W-1:0] h);
        logic [gwmn_pkg::CFG_IDX_W-1:0] regs [3];
        logic [gwmn_pkg::CFG_W-1:0]     vals [3];
        regs[0] = gwmn_pkg::REG_GRID_WIDTH;
        regs[1] = ($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B;
        regs[2] = gwmn_pkg::REG_GRID_HEIGHT;
        vals[0] = w;
        vals[1] = gwmn_pkg::CFG_W'($urandom_range(127));
        vals[2] = h;
        cfg_ch.valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            cfg_ch.index <= regs[k];
            cfg_ch.data  <= vals[k];
            do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
            board.set_reg(regs[k], vals[k]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Random paints and queries for one grid size. Query centers mostly sit
    // inside the grid or next to the last disc so that walls get hit.
    task automatic run_phase(input int w, input int h);
        int                           ew;
        int                           eh;
        int                           pick;
        int                           roll;
        logic                         kind;
        logic [gwmn_pkg::COORD_W-1:0] x;
        logic [gwmn_pkg::COORD_W-1:0] y;
        logic [gwmn_pkg::RAD_W-1:0]   r;
        logic [gwmn_pkg::COORD_W-1:0] hx;
        logic [gwmn_pkg::COORD_W-1:0] hy;
        ew = (w > GRID_SIDE) ? GRID_SIDE : w;
        eh = (h > GRID_SIDE) ? GRID_SIDE : h;
        hx = gwmn_pkg::COORD_W'($urandom_range(63));
        hy = gwmn_pkg::COORD_W'($urandom_range(63));
        write_grid_size(gwmn_pkg::CFG_W'(w), gwmn_pkg::CFG_W'(h));
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            kind = ($urandom_range(99) < 30) ? gwmn_pkg::KIND_PAINT : gwmn_pkg::KIND_QUERY;
            pick = $urandom_range(99);
            if (pick < 15 || ew == 0 || eh == 0) begin
                x = gwmn_pkg::COORD_W'($urandom_range(63));
                y = gwmn_pkg::COORD_W'($urandom_range(63));
            end else if (pick < 40) begin
                x = gwmn_pkg::COORD_W'(int'(hx) + int'($urandom_range(4)) - 2);
                y = gwmn_pkg::COORD_W'(int'(hy) + int'($urandom_range(4)) - 2);
            end else begin
                x = gwmn_pkg::COORD_W'($urandom_range(ew - 1));
                y = gwmn_pkg::COORD_W'($urandom_range(eh - 1));
            end
            roll = $urandom_range(99);
            if (roll < 70)
                r = gwmn_pkg::RAD_W'($urandom_range(48));
            else if (roll < 85)
                r = gwmn_pkg::RAD_W'($urandom_range(110, 49));
            else if (roll < 90)
                r = '0;
            else
                r = gwmn_pkg::RAD_W'($urandom_range(255, 111));
            if (kind == gwmn_pkg::KIND_PAINT) begin
                hx = x;
                hy = y;
            end
            feed_item(kind, x, y, r, (i == PAUSE_AT) || (i == PHASE_ITEMS - 1));
            // hold the sender off until the block has answered everything
            if (i == PAUSE_AT)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.kind   <= gwmn_pkg::KIND_PAINT;
        item_ch.cell_x <= '0;
        item_ch.cell_y <= '0;
        item_ch.radius <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= gwmn_pkg::REG_GRID_WIDTH;
        cfg_ch.data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Writes are taken during the clearing pass; items wait on ready.
        write_grid_size(gwmn_pkg::GRID_RESET, gwmn_pkg::GRID_RESET);

        // Directed: corners and middle of an empty map, zero radius,
        // one-cell and plus-shaped discs, a full-size disc that walls in
        // its center, and discs clipped by the grid edges.
        feed_item(gwmn_pkg::KIND_QUERY, 6'd0, 6'd0, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd63, 6'd63, 8'hff, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd30, 6'd30, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd0, 6'd63, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd63, 6'd0, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd10, 6'd10, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd10, 6'd10, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd10, 6'd10, 8'd16, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd11, 6'd11, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd10, 6'd10, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd20, 6'd20, 8'd17, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd20, 6'd20, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd40, 6'd40, 8'd255, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd40, 6'd40, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd40, 6'd56, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd0, 6'd0, 8'd40, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd1, 6'd3, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd63, 6'd0, 8'd255, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd62, 6'd17, 8'd0, 1'b0);
        feed_item(gwmn_pkg::KIND_PAINT, 6'd63, 6'd63, 8'd23, 1'b0);
        feed_item(gwmn_pkg::KIND_QUERY, 6'd62, 6'd62, 8'd0, 1'b1);
        drain_results();

        // Two phases per idle mode: slow receiver, slow sender, none.
        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 76;
                recv_idle_pct = 13;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(phase_w[p], phase_h[p]);
        end

        if (board.mismatches == 0 && board.pending_cells.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
